// File: design/euler_point_transform_assert.svh
// Assertion macros for the Euler point transform.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef EULER_POINT_TRANSFORM_ASSERT_SVH
`define EULER_POINT_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define EPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define EPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ept_pkg.sv
// Package for the Euler point transform: constants, angle folding and CORDIC table.
// Used by euler_point_transform; depends on nothing else.
`default_nettype none

package ept_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FracBits      = 16;
  localparam int unsigned TrigFrac      = 30;
  localparam int unsigned CordicSteps   = 20;
  localparam int unsigned AngleW        = 16;
  localparam int unsigned AngW          = 26;  // CORDIC residual angle, 2^-16 degree
  localparam int unsigned TrigW         = 33;  // sine and cosine, Q2.30 plus headroom

  localparam logic signed [17:0] AngleFull = 18'sd23040;
  localparam logic signed [17:0] AngleHalf = 18'sd11520;
  localparam logic signed [17:0] AngleQtr  = 18'sd5760;
  localparam logic signed [TrigW-1:0] CordicGain = 33'sd652032874;

  typedef struct packed {
    logic signed [AngW-1:0] t;
    logic                   flip;
  } trig_prep_t;

  // atan(2^-i) in units of 2^-16 degree.
  function automatic logic signed [AngW-1:0] atan_val(input int unsigned i);
    logic signed [AngW-1:0] r;
    case (i)
      0:  r = 26'sd2949120;
      1:  r = 26'sd1740967;
      2:  r = 26'sd919879;
      3:  r = 26'sd466945;
      4:  r = 26'sd234379;
      5:  r = 26'sd117304;
      6:  r = 26'sd58665;
      7:  r = 26'sd29335;
      8:  r = 26'sd14668;
      9:  r = 26'sd7334;
      10: r = 26'sd3667;
      11: r = 26'sd1833;
      12: r = 26'sd917;
      13: r = 26'sd458;
      14: r = 26'sd229;
      15: r = 26'sd115;
      16: r = 26'sd57;
      17: r = 26'sd29;
      18: r = 26'sd14;
      19: r = 26'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Reduce a 1/64 degree angle into [-90, 90] degrees; a fold by 180 sets flip.
  function automatic trig_prep_t trig_prep(input logic signed [AngleW-1:0] ang);
    logic signed [17:0] a;
    trig_prep_t r;
    a = 18'(ang);
    r.flip = 1'b0;
    if (a < 0) begin
      a = a + AngleFull;
      if (a < 0) begin
        a = a + AngleFull;
      end
    end else if (a >= AngleFull) begin
      a = a - AngleFull;
    end
    if (a > AngleHalf) begin
      a = a - AngleFull;
    end
    if (a > AngleQtr) begin
      a = a - AngleHalf;
      r.flip = 1'b1;
    end else if (a < -AngleQtr) begin
      a = a + AngleHalf;
      r.flip = 1'b1;
    end
    r.t = AngW'(a) <<< 10;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/euler_point_transform.sv
// Top level of the Euler point transform: scale, rotate X/Y/Z, translate.
// Depends on ept_pkg and euler_point_transform_assert.svh.
//
// Usage: one request on the slave stream carries a local point, its per-axis
// scale, three angles in 1/64 degree and an offset; one request on the master
// stream returns the world point. Every field is signed; coordinates are Q16.16
// at the default COORD_WIDTH of 32.
// The pipeline has 28 register stages. A new request can be accepted in every
// cycle while no result waits on a stalled receiver, giving one point per cycle
// sustained; the 20 CORDIC stages for sine and cosine set the depth, and the
// rotation multipliers each take one stage plus one to sum.
// Reset clears every valid bit, so the block comes out of reset empty and ready.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline freezes and s_axis_tready drops in the same cycle; nothing is lost
// or repeated, and the flow resumes as soon as the result is taken.
`default_nettype none

module euler_point_transform #(
  parameter int unsigned COORD_WIDTH = ept_pkg::CoordWidthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // point_x, point_y, point_z, scale_x, scale_y, scale_z, angle_x, angle_y,
  // angle_z, offset_x, offset_y, offset_z (lowest bit up), zero padded
  input  wire logic [((9*COORD_WIDTH+3*ept_pkg::AngleW+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // world_x, world_y, world_z (lowest bit up), zero padded
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned AW   = ept_pkg::AngW;
  localparam int unsigned TW   = ept_pkg::TrigW;
  localparam int unsigned TF   = ept_pkg::TrigFrac;
  localparam int unsigned NC   = ept_pkg::CordicSteps;
  localparam int unsigned GW   = ept_pkg::AngleW;
  localparam int unsigned RW   = W + 2;
  localparam int unsigned PW   = RW + TW;
  localparam int unsigned SW   = 2 * W;
  localparam int unsigned ANG_OFS = 6 * W;
  localparam int unsigned OFF_OFS = 6 * W + 3 * GW;
  localparam int unsigned ST_MX = NC + 1;   // X rotation products
  localparam int unsigned ST_SX = NC + 2;   // X rotation sums
  localparam int unsigned ST_MY = NC + 3;
  localparam int unsigned ST_SY = NC + 4;
  localparam int unsigned ST_MZ = NC + 5;
  localparam int unsigned ST_SZ = NC + 6;
  localparam int unsigned ST_OUT = NC + 7;

  // Saturate a wide signed value to W bits.
  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    logic signed [W-1:0] r;
    if ((v[SW-1:W-1] == '0) || (v[SW-1:W-1] == '1)) begin
      r = v[W-1:0];
    end else begin
      r = {v[SW-1], {(W-1){~v[SW-1]}}};
    end
    return r;
  endfunction

  // Sum or difference of two floored trig products, saturated to RW bits.
  function automatic logic signed [RW-1:0] rot_sum(input logic signed [PW-1:0] a,
                                                   input logic signed [PW-1:0] b,
                                                   input logic sub);
    logic signed [PW:0] ea;
    logic signed [PW:0] eb;
    logic signed [PW:0] s;
    logic signed [RW-1:0] r;
    ea = $signed({a[PW-1], a}) >>> TF;
    eb = $signed({b[PW-1], b}) >>> TF;
    s  = sub ? (ea - eb) : (ea + eb);
    if ((s[PW:RW-1] == '0) || (s[PW:RW-1] == '1)) begin
      r = s[RW-1:0];
    end else begin
      r = {s[PW], {(RW-1){~s[PW]}}};
    end
    return r;
  endfunction

  logic en;
  logic [ST_OUT:0] vld_q;

  logic signed [W-1:0]  pt_in  [3];
  logic signed [W-1:0]  sc_in  [3];
  logic signed [GW-1:0] ang_in [3];
  logic signed [W-1:0]  off_in [3];

  logic signed [SW-1:0] prod_q [3];
  logic signed [AW-1:0] ang_q  [0:NC][3];
  logic signed [TW-1:0] cs_q   [0:NC][3];
  logic signed [TW-1:0] sn_q   [0:NC][3];
  logic                 flp_q  [0:NC][3];
  logic signed [W-1:0]  crd_q  [1:NC][3];
  logic signed [W-1:0]  off_q  [0:ST_SZ][3];

  logic signed [TW-1:0] tc_q   [ST_MX:ST_MZ][3];
  logic signed [TW-1:0] ts_q   [ST_MX:ST_MZ][3];
  logic signed [PW-1:0] mp_q   [ST_MX:ST_MZ][4];
  logic signed [RW-1:0] rx_q   [ST_MX:ST_SZ];
  logic signed [RW-1:0] ry_q   [ST_MX:ST_SZ];
  logic signed [RW-1:0] rz_q   [ST_MX:ST_SZ];
  logic signed [W-1:0]  wld_q  [3];

  // The pipeline moves as one; it stops only while a finished result waits.
  assign en            = !(vld_q[ST_OUT] && !m_axis_tready);
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[ST_OUT];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pt_in[a]  = s_axis_tdata[a*W +: W];
      sc_in[a]  = s_axis_tdata[(3+a)*W +: W];
      ang_in[a] = s_axis_tdata[ANG_OFS + a*GW +: GW];
      off_in[a] = s_axis_tdata[OFF_OFS + a*W +: W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ST_OUT-1:0], s_axis_tvalid};
    end
  end

  // Stage 0: scale products and angle folding.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        ept_pkg::trig_prep_t tp;
        tp = ept_pkg::trig_prep(ang_in[a]);
        prod_q[a]   <= pt_in[a] * sc_in[a];
        ang_q[0][a] <= tp.t;
        flp_q[0][a] <= tp.flip;
        cs_q[0][a]  <= ept_pkg::CordicGain;
        sn_q[0][a]  <= '0;
      end
    end
  end

  // Offsets ride alongside the data until the translation stage.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        off_q[0][a] <= off_in[a];
        for (int k = 1; k <= ST_SZ; k++) begin
          off_q[k][a] <= off_q[k-1][a];
        end
      end
    end
  end

  // The scaled point is saturated in stage 1 and then held beside the CORDIC.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        crd_q[1][a] <= sat_w(prod_q[a] >>> ept_pkg::FracBits);
        for (int k = 2; k <= NC; k++) begin
          crd_q[k][a] <= crd_q[k-1][a];
        end
      end
    end
  end

  // Stages 1 to NC: one CORDIC rotation per stage for all three angles.
  for (genvar k = 1; k <= NC; k++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int a = 0; a < 3; a++) begin
          if (!ang_q[k-1][a][AW-1]) begin
            cs_q[k][a]  <= cs_q[k-1][a] - (sn_q[k-1][a] >>> (k-1));
            sn_q[k][a]  <= sn_q[k-1][a] + (cs_q[k-1][a] >>> (k-1));
            ang_q[k][a] <= ang_q[k-1][a] - ept_pkg::atan_val(k-1);
          end else begin
            cs_q[k][a]  <= cs_q[k-1][a] + (sn_q[k-1][a] >>> (k-1));
            sn_q[k][a]  <= sn_q[k-1][a] - (cs_q[k-1][a] >>> (k-1));
            ang_q[k][a] <= ang_q[k-1][a] + ept_pkg::atan_val(k-1);
          end
          flp_q[k][a] <= flp_q[k-1][a];
        end
      end
    end
  end

  // Rotation about X, then Y, then Z; each product is registered before its sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        tc_q[ST_MX][a] <= flp_q[NC][a] ? -cs_q[NC][a] : cs_q[NC][a];
        ts_q[ST_MX][a] <= flp_q[NC][a] ? -sn_q[NC][a] : sn_q[NC][a];
        for (int k = ST_MX + 1; k <= ST_MZ; k++) begin
          tc_q[k][a] <= tc_q[k-1][a];
          ts_q[k][a] <= ts_q[k-1][a];
        end
      end

      // X: y' = y*cx - z*sx, z' = y*sx + z*cx
      mp_q[ST_MX][0] <= PW'(crd_q[NC][1]) * PW'(flp_q[NC][0] ? -cs_q[NC][0] : cs_q[NC][0]);
      mp_q[ST_MX][1] <= PW'(crd_q[NC][2]) * PW'(flp_q[NC][0] ? -sn_q[NC][0] : sn_q[NC][0]);
      mp_q[ST_MX][2] <= PW'(crd_q[NC][1]) * PW'(flp_q[NC][0] ? -sn_q[NC][0] : sn_q[NC][0]);
      mp_q[ST_MX][3] <= PW'(crd_q[NC][2]) * PW'(flp_q[NC][0] ? -cs_q[NC][0] : cs_q[NC][0]);
      rx_q[ST_MX]    <= RW'(crd_q[NC][0]);
      ry_q[ST_MX]    <= '0;
      rz_q[ST_MX]    <= '0;

      rx_q[ST_SX] <= rx_q[ST_MX];
      ry_q[ST_SX] <= rot_sum(mp_q[ST_MX][0], mp_q[ST_MX][1], 1'b1);
      rz_q[ST_SX] <= rot_sum(mp_q[ST_MX][2], mp_q[ST_MX][3], 1'b0);

      // Y: x' = x*cy + z*sy, z' = z*cy - x*sy
      mp_q[ST_MY][0] <= PW'(rx_q[ST_SX]) * PW'(tc_q[ST_MY-1][1]);
      mp_q[ST_MY][1] <= PW'(rz_q[ST_SX]) * PW'(ts_q[ST_MY-1][1]);
      mp_q[ST_MY][2] <= PW'(rz_q[ST_SX]) * PW'(tc_q[ST_MY-1][1]);
      mp_q[ST_MY][3] <= PW'(rx_q[ST_SX]) * PW'(ts_q[ST_MY-1][1]);
      rx_q[ST_MY]    <= '0;
      ry_q[ST_MY]    <= ry_q[ST_SX];
      rz_q[ST_MY]    <= '0;

      rx_q[ST_SY] <= rot_sum(mp_q[ST_MY][0], mp_q[ST_MY][1], 1'b0);
      ry_q[ST_SY] <= ry_q[ST_MY];
      rz_q[ST_SY] <= rot_sum(mp_q[ST_MY][2], mp_q[ST_MY][3], 1'b1);

      // Z: x' = x*cz - y*sz, y' = x*sz + y*cz
      mp_q[ST_MZ][0] <= PW'(rx_q[ST_SY]) * PW'(tc_q[ST_MZ-1][2]);
      mp_q[ST_MZ][1] <= PW'(ry_q[ST_SY]) * PW'(ts_q[ST_MZ-1][2]);
      mp_q[ST_MZ][2] <= PW'(rx_q[ST_SY]) * PW'(ts_q[ST_MZ-1][2]);
      mp_q[ST_MZ][3] <= PW'(ry_q[ST_SY]) * PW'(tc_q[ST_MZ-1][2]);
      rx_q[ST_MZ]    <= '0;
      ry_q[ST_MZ]    <= '0;
      rz_q[ST_MZ]    <= rz_q[ST_SY];

      rx_q[ST_SZ] <= rot_sum(mp_q[ST_MZ][0], mp_q[ST_MZ][1], 1'b1);
      ry_q[ST_SZ] <= rot_sum(mp_q[ST_MZ][2], mp_q[ST_MZ][3], 1'b0);
      rz_q[ST_SZ] <= rz_q[ST_MZ];

      // Translation with saturation into the output register.
      wld_q[0] <= sat_w(SW'(rx_q[ST_SZ]) + SW'(off_q[ST_SZ][0]));
      wld_q[1] <= sat_w(SW'(ry_q[ST_SZ]) + SW'(off_q[ST_SZ][1]));
      wld_q[2] <= sat_w(SW'(rz_q[ST_SZ]) + SW'(off_q[ST_SZ][2]));
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int a = 0; a < 3; a++) begin
      m_axis_tdata[a*W +: W] = wld_q[a];
    end
  end

  `include "euler_point_transform_assert.svh"

  `EPT_ASSERT_IMP(a_stall_blocks_input, vld_q[ST_OUT] && !m_axis_tready, !s_axis_tready, "input taken while output stalled")
  `EPT_ASSERT_NXT(a_accept_enters_pipe, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted request missing from stage 0")
  `EPT_ASSERT_NXT(a_stall_freezes_pipe, !en, vld_q == $past(vld_q), "pipeline moved while stalled")
  `EPT_ASSERT_IMP(a_cordic_in_range, vld_q[NC], cs_q[NC][0][TW-1] == cs_q[NC][0][TW-2], "cosine left its range")

endmodule

`default_nettype wire

// File: sim/euler_point_transform_tb.sv
// Testbench for euler_point_transform: drives point requests on the slave stream and checks
// each world point against a behavioral predictor with its own angle folding and CORDIC.
// Depends on ept_pkg and the euler_point_transform RTL.
`default_nettype none

module euler_point_transform_tb;

  localparam int unsigned CW     = 32;
  localparam int unsigned IN_W   = ((9*CW+3*ept_pkg::AngleW+7)/8)*8;
  localparam int unsigned OUT_W  = ((3*CW+7)/8)*8;
  localparam int unsigned LATENCY = 28;

  typedef struct packed {
    logic signed [CW-1:0] off_z, off_y, off_x;
    logic signed [15:0]   ang_z, ang_y, ang_x;
    logic signed [CW-1:0] scl_z, scl_y, scl_x;
    logic signed [CW-1:0] pt_z, pt_y, pt_x;
  } point_req_t;

  typedef struct packed {
    logic signed [CW-1:0] wz, wy, wx;
  } world_pt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit snk_hold = 1'b0;
  int unsigned errors = 0;
  world_pt_t expected_points[$];

  always #5 clk_i = ~clk_i;

  euler_point_transform #(.COORD_WIDTH(CW)) i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Saturate a wide signed value to a given number of bits.
  function automatic longint clamp_bits(input longint v, input int unsigned bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // floor(a*b / 2^sh) with a 128-bit product, clamped to +-2^62.
  function automatic longint mul_floor(input longint a, input longint b, input int unsigned sh);
    logic signed [127:0] p;
    logic signed [127:0] cap;
    p = (128'(signed'(a)) * 128'(signed'(b))) >>> sh;
    cap = 128'sd1 <<< 62;
    if (p > cap) p = cap;
    if (p < -cap) p = -cap;
    return longint'(p);
  endfunction

  // Cosine and sine in Q2.30 for a 1/64 degree angle.
  function automatic void angle_trig(input logic signed [15:0] ang, output longint c,
                                     output longint s);
    longint a, t, x, y, dx, dy;
    bit flip;
    a = longint'(ang) % 23040;
    if (a < 0) a += 23040;
    t = a * 1024;
    flip = 1'b0;
    if (t > 180 * 65536) t -= 360 * 65536;
    if (t > 90 * 65536) begin
      t -= 180 * 65536;
      flip = 1'b1;
    end else if (t < -90 * 65536) begin
      t += 180 * 65536;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (t >= 0) begin
        x -= dx; y += dy; t -= longint'(ept_pkg::atan_val(i));
      end else begin
        x += dx; y -= dy; t += longint'(ept_pkg::atan_val(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint rotate_term(input longint a, input longint ta, input longint b,
                                         input longint tb, input bit sub);
    longint p, q;
    p = mul_floor(a, ta, 30);
    q = mul_floor(b, tb, 30);
    return clamp_bits(sub ? p - q : p + q, CW + 2);
  endfunction

  function automatic world_pt_t transform_point(input point_req_t r);
    longint x, y, z, nx, ny, nz, cx, sx, cy, sy, cz, sz;
    world_pt_t w;
    x = clamp_bits(mul_floor(r.pt_x, r.scl_x, 16), CW);
    y = clamp_bits(mul_floor(r.pt_y, r.scl_y, 16), CW);
    z = clamp_bits(mul_floor(r.pt_z, r.scl_z, 16), CW);
    angle_trig(r.ang_x, cx, sx);
    angle_trig(r.ang_y, cy, sy);
    angle_trig(r.ang_z, cz, sz);
    ny = rotate_term(y, cx, z, sx, 1'b1);
    nz = rotate_term(y, sx, z, cx, 1'b0);
    y = ny; z = nz;
    nx = rotate_term(x, cy, z, sy, 1'b0);
    nz = rotate_term(z, cy, x, sy, 1'b1);
    x = nx; z = nz;
    nx = rotate_term(x, cz, y, sz, 1'b1);
    ny = rotate_term(x, sz, y, cz, 1'b0);
    w.wx = CW'(clamp_bits(nx + longint'(r.off_x), CW));
    w.wy = CW'(clamp_bits(ny + longint'(r.off_y), CW));
    w.wz = CW'(clamp_bits(z + longint'(r.off_z), CW));
    return w;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return 16'(5760 * $urandom_range(0, 5)) - 16'(11520 * $urandom_range(0, 2));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one request, waiting for acceptance with random idle cycles first.
  // The request stays valid after acceptance; the caller drops it when the sender stops.
  task automatic send_request(input point_req_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= IN_W'(r);
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_points.push_back(transform_point(r));
    @(negedge clk_i);
  endtask

  // Receiver ready: random stalls, or a forced long hold-off.
  always @(negedge clk_i) begin
    m_axis_tready <= !snk_hold && ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Compare every accepted world point with the oldest pending expectation.
  always @(posedge clk_i) begin
    world_pt_t got, exp_pt;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = world_pt_t'(m_axis_tdata[3*CW-1:0]);
      if (expected_points.size() == 0) begin
        $error("world point with no request pending: %h", got);
        errors++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (got.wx !== exp_pt.wx) begin
          $error("world_x expected %0d got %0d", exp_pt.wx, got.wx); errors++;
        end
        if (got.wy !== exp_pt.wy) begin
          $error("world_y expected %0d got %0d", exp_pt.wy, got.wy); errors++;
        end
        if (got.wz !== exp_pt.wz) begin
          $error("world_z expected %0d got %0d", exp_pt.wz, got.wz); errors++;
        end
      end
    end
  end

  // Directed rows: point, scale, angles, offset, and the expected world point where known.
  typedef struct {
    point_req_t req;
    bit         known;
    world_pt_t  res;
  } directed_row_t;

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] MINC = 32'h8000_0000;

  directed_row_t rows[$];

  function automatic point_req_t mk(input logic [31:0] px, py, pz, sx, sy, sz,
                                    input logic [15:0] ax, ay, az,
                                    input logic [31:0] ox, oy, oz);
    point_req_t r;
    r.pt_x = px; r.pt_y = py; r.pt_z = pz;
    r.scl_x = sx; r.scl_y = sy; r.scl_z = sz;
    r.ang_x = ax; r.ang_y = ay; r.ang_z = az;
    r.off_x = ox; r.off_y = oy; r.off_z = oz;
    return r;
  endfunction

  task automatic add_row(input point_req_t r, input bit known, input world_pt_t w);
    directed_row_t d;
    d.req = r; d.known = known; d.res = w;
    rows.push_back(d);
  endtask

  initial begin
    point_req_t r;
    world_pt_t w;
    w = '0;
    // All zero gives the origin; pure offsets pass straight through.
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
    w.wx = 32'sd5; w.wy = -32'sd7; w.wz = 32'sd123456;
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 5, -7, 123456), 1'b1, w);
    // Offset extremes with a zero point.
    w.wx = MAXC; w.wy = MINC; w.wz = MAXC;
    add_row(mk(0, 0, 0, ONE, ONE, ONE, 16'h7fff, 16'h8000, 0, MAXC, MINC, MAXC), 1'b1, w);
    // Scale overflow saturates, then the final sum saturates.
    add_row(mk(MAXC, MINC, MAXC, MAXC, MAXC, MINC, 0, 0, 0, MAXC, MINC, MINC), 1'b0, w);
    add_row(mk(MINC, MINC, MINC, MINC, MINC, MINC, 0, 0, 0, MINC, MINC, MINC), 1'b0, w);
    add_row(mk(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 0, 0, 0, MAXC, MAXC, MAXC), 1'b0, w);
    // Angle reduction: quarter turns, half turns, folds and the 16-bit extremes.
    add_row(mk(ONE, ONE, ONE, ONE, ONE, ONE, 16'd5760, 0, 0, 0, 0, 0), 1'b0, w);
    add_row(mk(ONE, ONE, ONE, ONE, ONE, ONE, 0, 16'd11520, 0, 0, 0, 0), 1'b0, w);
    add_row(mk(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 16'd17280, 0, 0, 0), 1'b0, w);
    add_row(mk(ONE, ONE, ONE, ONE, ONE, ONE, 16'd23040, 16'd23040, 16'd23040, 0, 0, 0), 1'b0, w);
    add_row(mk(ONE, ONE, ONE, ONE, ONE, ONE, -16'sd5760, -16'sd11520, -16'sd17281,
               0, 0, 0), 1'b0, w);
    add_row(mk(ONE, 2*ONE, 3*ONE, ONE, ONE, ONE, 16'h7fff, 16'h8000, 16'hffff, 0, 0, 0), 1'b0, w);
    add_row(mk(ONE, 2*ONE, 3*ONE, ONE, ONE, ONE, 16'd5761, 16'd5759, 16'd11521, 0, 0, 0), 1'b0, w);
    add_row(mk(MAXC, MAXC, MAXC, ONE, ONE, ONE, 16'd2880, 16'd2880, 16'd2880,
               MAXC, MAXC, MAXC), 1'b0, w);
    add_row(mk(MINC, MINC, MINC, ONE, ONE, ONE, 16'd8640, 16'd8640, 16'd8640,
               MINC, MINC, MINC), 1'b0, w);
    add_row(mk(32'hffff_ffff, 1, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff, 1,
               16'h5555, 16'haaaa, 16'h0001, 32'haaaa_aaaa, 32'h5555_5555, 1), 1'b0, w);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        if (transform_point(rows[i].req) !== rows[i].res) begin
          $error("directed row %0d: predictor disagrees with table", i);
          errors++;
        end
      end
      send_request(rows[i].req);
    end

    // Three idle phases of random requests, then a long receiver hold-off.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 47 : 0;
      snk_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 27 : 0;
      for (int n = 0; n < 300; n++) begin
        r = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_angle(), rand_angle(), rand_angle(), rand_coord(),
               rand_coord(), rand_coord());
        send_request(r);
      end
      s_axis_tvalid <= 1'b0;
      // Sender pauses until every pending world point has been returned.
      while (expected_points.size() != 0) @(negedge clk_i);
    end

    fork
      begin
        snk_hold = 1'b1;
        repeat (200) @(negedge clk_i);
        snk_hold = 1'b0;
      end
      begin
        for (int n = 0; n < 60; n++) begin
          r = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_angle(), rand_angle(), rand_angle(), rand_coord(),
                 rand_coord(), rand_coord());
          send_request(r);
        end
        s_axis_tvalid <= 1'b0;
      end
    join

    while (expected_points.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("euler_point_transform_tb passed");
    end else begin
      $display("euler_point_transform_tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("euler_point_transform_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
